[hw/rtl/lss_pkg.sv]
// Shared types, codes and constants for the LIFO stack core.
package lss_pkg;

  localparam int LSS_STACK_DEPTH = 64;
  localparam int LSS_DATA_W      = 32;

  typedef logic [1:0] req_t;
  typedef logic [1:0] status_t;
  typedef logic [1:0] addr_sel_t;
  typedef logic [1:0] wd_sel_t;

  localparam req_t REQ_PUSH  = 2'd0;
  localparam req_t REQ_POP   = 2'd1;
  localparam req_t REQ_SWAP  = 2'd2;
  localparam req_t REQ_PRINT = 2'd3;

  localparam status_t ST_OK         = 2'd0;
  localparam status_t ST_POP_EMPTY  = 2'd1;
  localparam status_t ST_SWAP_SHORT = 2'd2;
  localparam status_t ST_PUSH_FULL  = 2'd3;

  localparam addr_sel_t ADDR_COUNT  = 2'd0;
  localparam addr_sel_t ADDR_TOP    = 2'd1;
  localparam addr_sel_t ADDR_SECOND = 2'd2;
  localparam addr_sel_t ADDR_PTR_DN = 2'd3;

  localparam wd_sel_t WD_VALUE = 2'd0;
  localparam wd_sel_t WD_RDATA = 2'd1;
  localparam wd_sel_t WD_TMP   = 2'd2;

  typedef struct packed {
    logic      latch_req;
    logic      mem_rd;
    logic      mem_wr;
    addr_sel_t addr_sel;
    wd_sel_t   wd_sel;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      tmp_ld;
    logic      ptr_ld;
    logic      ptr_dec;
    logic      emit;
    logic      emit_entry;
    status_t   status;
    logic      last;
  } cmd_t;

  typedef struct packed {
    req_t req_type;
    logic count_zero;
    logic count_lt2;
    logic full;
    logic ptr_zero;
    logic out_free;
  } sts_t;

endpackage

[hw/rtl/lss_ctrl.sv]
// Controller state machine that sequences each stack request.
module lss_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lss_pkg::sts_t sts,
  output lss_pkg::cmd_t cmd
);
  import lss_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_SW_RB   = 3'd2;
  localparam logic [2:0] S_SW_WA   = 3'd3;
  localparam logic [2:0] S_SW_WB   = 3'd4;
  localparam logic [2:0] S_PR_EMIT = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_req = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.req_type)
          REQ_PUSH: begin
            if (sts.out_free) begin
              cmd.emit = 1'b1;
              cmd.last = 1'b1;
              if (sts.full) begin
                cmd.status = ST_PUSH_FULL;
              end else begin
                cmd.mem_wr   = 1'b1;
                cmd.addr_sel = ADDR_COUNT;
                cmd.wd_sel   = WD_VALUE;
                cmd.cnt_inc  = 1'b1;
              end
              state_nxt = S_IDLE;
            end
          end
          REQ_POP: begin
            if (sts.out_free) begin
              cmd.emit = 1'b1;
              cmd.last = 1'b1;
              if (sts.count_zero) begin
                cmd.status = ST_POP_EMPTY;
              end else begin
                cmd.cnt_dec = 1'b1;
              end
              state_nxt = S_IDLE;
            end
          end
          REQ_SWAP: begin
            if (sts.count_lt2) begin
              if (sts.out_free) begin
                cmd.emit   = 1'b1;
                cmd.last   = 1'b1;
                cmd.status = ST_SWAP_SHORT;
                state_nxt  = S_IDLE;
              end
            end else begin
              cmd.mem_rd   = 1'b1;
              cmd.addr_sel = ADDR_TOP;
              state_nxt    = S_SW_RB;
            end
          end
          REQ_PRINT: begin
            if (sts.count_zero) begin
              if (sts.out_free) begin
                cmd.emit  = 1'b1;
                cmd.last  = 1'b1;
                state_nxt = S_IDLE;
              end
            end else begin
              cmd.mem_rd   = 1'b1;
              cmd.addr_sel = ADDR_TOP;
              cmd.ptr_ld   = 1'b1;
              state_nxt    = S_PR_EMIT;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SW_RB: begin
        cmd.tmp_ld   = 1'b1;
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = ADDR_SECOND;
        state_nxt    = S_SW_WA;
      end
      S_SW_WA: begin
        cmd.mem_wr   = 1'b1;
        cmd.addr_sel = ADDR_TOP;
        cmd.wd_sel   = WD_RDATA;
        state_nxt    = S_SW_WB;
      end
      S_SW_WB: begin
        if (sts.out_free) begin
          cmd.mem_wr   = 1'b1;
          cmd.addr_sel = ADDR_SECOND;
          cmd.wd_sel   = WD_TMP;
          cmd.emit     = 1'b1;
          cmd.last     = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_PR_EMIT: begin
        if (sts.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_entry = 1'b1;
          cmd.last       = sts.ptr_zero;
          if (sts.ptr_zero) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.ptr_dec  = 1'b1;
            cmd.mem_rd   = 1'b1;
            cmd.addr_sel = ADDR_PTR_DN;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hw/rtl/lss_dpath.sv]
// Datapath with the entry memory, entry count, print pointer and result register.
module lss_dpath #(
  parameter int STACK_DEPTH = lss_pkg::LSS_STACK_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lss_pkg::req_t                     in_req_type,
  input  logic signed [lss_pkg::LSS_DATA_W-1:0] in_push_value,
  input  lss_pkg::cmd_t                     cmd,
  output lss_pkg::sts_t                     sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [lss_pkg::LSS_DATA_W-1:0] out_entry_value,
  output logic                              out_has_entry,
  output lss_pkg::status_t                  out_status,
  output logic                              out_last_of_run
);
  import lss_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [LSS_DATA_W-1:0] store_r [STACK_DEPTH];
  logic [LSS_DATA_W-1:0] rd_data_r;
  logic [LSS_DATA_W-1:0] tmp_r;
  logic [LSS_DATA_W-1:0] value_r;
  req_t                  req_type_r;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic [AW-1:0]         ptr_r;
  logic [AW-1:0]         top_addr;
  logic [AW-1:0]         addr;
  logic [LSS_DATA_W-1:0] wr_data;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [LSS_DATA_W-1:0] out_value_r;
  logic                  out_has_r;
  status_t               out_status_r;
  logic                  out_last_r;

  assign top_addr = AW'(count_r - 1'b1);

  always_comb begin
    unique case (cmd.addr_sel)
      ADDR_COUNT:  addr = count_r[AW-1:0];
      ADDR_TOP:    addr = top_addr;
      ADDR_SECOND: addr = AW'(count_r - CW'(2));
      ADDR_PTR_DN: addr = ptr_r - 1'b1;
      default:     addr = top_addr;
    endcase
  end

  always_comb begin
    unique case (cmd.wd_sel)
      WD_VALUE: wr_data = value_r;
      WD_RDATA: wr_data = rd_data_r;
      WD_TMP:   wr_data = tmp_r;
      default:  wr_data = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      store_r[addr] <= wr_data;
    end
    if (cmd.mem_rd) begin
      rd_data_r <= store_r[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_type_r <= in_req_type;
      value_r    <= in_push_value;
    end
    if (cmd.tmp_ld) begin
      tmp_r <= rd_data_r;
    end
    if (cmd.ptr_ld) begin
      ptr_r <= top_addr;
    end else if (cmd.ptr_dec) begin
      ptr_r <= ptr_r - 1'b1;
    end
    if (cmd.emit) begin
      out_value_r  <= cmd.emit_entry ? rd_data_r : '0;
      out_has_r    <= cmd.emit_entry;
      out_status_r <= cmd.status;
      out_last_r   <= cmd.last;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign sts.req_type   = req_type_r;
  assign sts.count_zero = (count_r == '0);
  assign sts.count_lt2  = (count_r < CW'(2));
  assign sts.full       = (count_r == CW'(STACK_DEPTH));
  assign sts.ptr_zero   = (ptr_r == '0);
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_entry_value = out_value_r;
  assign out_has_entry   = out_has_r;
  assign out_status      = out_status_r;
  assign out_last_of_run = out_last_r;

endmodule

[hw/rtl/lifo_stack_push_pop_swap_core.sv]
// Top level of the LIFO stack core: controller, datapath and checks.
// The block holds up to STACK_DEPTH signed 32-bit entries in a single-port memory.
// Requests arrive on the in_ channel (in_req_type, in_push_value) under valid/ready;
// results leave on the out_ channel under valid/ready from an output register.
// Push, pop and swap give one result with a status code; print gives one result per
// entry from top to bottom and marks the final one with out_last_of_run.
// A request is accepted only while the controller is idle. Push and pop register their
// result from the execute state. Swap reads the top and then the second entry, writes
// the second into the top slot and the top into the second, and registers its result
// with the last write. Print reads the top entry, then registers each entry while it
// reads the next, since every step goes through the one memory port. An empty print
// gives one result without an entry.
// The next request is taken in the cycle after a request finishes, even while its
// last result still waits in the output register.
// When the receiver stalls, the result stays in the output register and the
// controller holds before issuing the next result, so nothing is lost or repeated.
// Reset clears the entry count and the control state; memory contents are not cleared
// and are never read before they are written.
module lifo_stack_push_pop_swap_core #(
  parameter int STACK_DEPTH = lss_pkg::LSS_STACK_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  lss_pkg::req_t                         in_req_type,
  input  logic signed [lss_pkg::LSS_DATA_W-1:0] in_push_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [lss_pkg::LSS_DATA_W-1:0] out_entry_value,
  output logic                                  out_has_entry,
  output lss_pkg::status_t                      out_status,
  output logic                                  out_last_of_run
);
  import lss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lss_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_req_type     (in_req_type),
    .in_push_value   (in_push_value),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_entry_value (out_entry_value),
    .out_has_entry   (out_has_entry),
    .out_status      (out_status),
    .out_last_of_run (out_last_of_run)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while the previous one is still in progress");

  a_entry_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_entry |-> out_status == ST_OK)
    else $error("entry result carries a refusal status");

  a_mid_run_is_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> out_has_entry)
    else $error("non-final result without an entry");

  a_refusal_is_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last_of_run && !out_has_entry)
    else $error("refusal result is not a single final result");

endmodule

[verif/tb_lifo_stack_push_pop_swap_core.sv]
// Self-checking testbench for the LIFO stack core with a shadow-stack scoreboard.
`timescale 1ns / 1ps

module tb_lifo_stack_push_pop_swap_core;
  import lss_pkg::*;

  localparam int STACK_DEPTH  = LSS_STACK_DEPTH;
  localparam int RANDOM_ITEMS = 180;
  localparam int LONG_HOLD    = 200;
  localparam int TAIL_CYCLES  = 2 * STACK_DEPTH + 20;

  typedef struct {
    logic signed [LSS_DATA_W-1:0] entry_value;
    logic                         has_entry;
    status_t                      status;
    logic                         last_of_run;
  } stack_result_t;

  class stack_scoreboard;
    int                           depth_limit;
    logic signed [LSS_DATA_W-1:0] shadow[$];
    stack_result_t                expected_q[$];
    int unsigned                  mismatches;
    int unsigned                  results_checked;
    int unsigned                  peak_depth;
    int unsigned                  req_seen[4];
    int unsigned                  refusals[4];

    function new(int depth);
      depth_limit = depth;
    endfunction

    function void note_request(req_t req, logic signed [LSS_DATA_W-1:0] value);
      stack_result_t                r;
      logic signed [LSS_DATA_W-1:0] t;
      int                           n;
      int                           i;
      r.entry_value = '0;
      r.has_entry   = 1'b0;
      r.status      = ST_OK;
      r.last_of_run = 1'b1;
      n = shadow.size();
      req_seen[req]++;
      case (req)
        REQ_PUSH: begin
          if (n >= depth_limit) r.status = ST_PUSH_FULL;
          else shadow.push_back(value);
        end
        REQ_POP: begin
          if (n == 0) r.status = ST_POP_EMPTY;
          else void'(shadow.pop_back());
        end
        REQ_SWAP: begin
          if (n < 2) begin
            r.status = ST_SWAP_SHORT;
          end else begin
            t            = shadow[n-1];
            shadow[n-1]  = shadow[n-2];
            shadow[n-2]  = t;
          end
        end
        default: begin
          // A print of a non-empty stack walks it from the top down.
          if (n > 0) begin
            for (i = n - 1; i >= 0; i--) begin
              r.entry_value = shadow[i];
              r.has_entry   = 1'b1;
              r.last_of_run = (i == 0);
              expected_q.push_back(r);
            end
            return;
          end
        end
      endcase
      if (r.status != ST_OK) refusals[r.status]++;
      if (shadow.size() > peak_depth) peak_depth = shadow.size();
      expected_q.push_back(r);
    endfunction

    function void check_result(stack_result_t got);
      stack_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result value=%0d has=%0b status=%0d last=%0b",
                   $realtime, got.entry_value, got.has_entry, got.status, got.last_of_run);
        return;
      end
      want = expected_q.pop_front();
      results_checked++;
      if (got.entry_value !== want.entry_value || got.has_entry !== want.has_entry ||
          got.status !== want.status || got.last_of_run !== want.last_of_run) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp value=%0d has=%0b status=%0d last=%0b, got value=%0d has=%0b status=%0d last=%0b",
                   $realtime, want.entry_value, want.has_entry, want.status, want.last_of_run,
                   got.entry_value, got.has_entry, got.status, got.last_of_run);
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  req_t                         in_req_type = REQ_PUSH;
  logic signed [LSS_DATA_W-1:0] in_push_value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic signed [LSS_DATA_W-1:0] out_entry_value;
  logic                         out_has_entry;
  status_t                      out_status;
  logic                         out_last_of_run;

  stack_scoreboard sb = new(STACK_DEPTH);
  int              gap_max = 6;
  bit              long_hold_req = 1'b0;

  lifo_stack_push_pop_swap_core #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_push_value  (in_push_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_entry_value(out_entry_value),
    .out_has_entry  (out_has_entry),
    .out_status     (out_status),
    .out_last_of_run(out_last_of_run)
  );

  always #5 clk = ~clk;

  task automatic send_request(req_t req, logic signed [LSS_DATA_W-1:0] value);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_push_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(req, value);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [LSS_DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t pick_request(int mode);
    int roll;
    roll = $urandom_range(0, 99);
    if (mode == 1) begin
      if (roll < 60) return REQ_PUSH;
      if (roll < 75) return REQ_POP;
      if (roll < 90) return REQ_SWAP;
      return REQ_PRINT;
    end
    if (mode == 2) begin
      if (roll < 20) return REQ_PUSH;
      if (roll < 75) return REQ_POP;
      if (roll < 90) return REQ_SWAP;
      return REQ_PRINT;
    end
    return req_t'(roll % 4);
  endfunction

  initial begin : result_sink
    int            stall;
    int            stall_max;
    int            stretch;
    stack_result_t got;
    stall_max = 6;
    stretch   = $urandom_range(20, 40);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        stall         = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        stall = $urandom_range(0, stall_max);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.entry_value = out_entry_value;
      got.has_entry   = out_has_entry;
      got.status      = out_status;
      got.last_of_run = out_last_of_run;
      sb.check_result(got);
      stretch--;
      if (stretch == 0) begin
        stall_max = (stall_max == 0) ? 6 : 0;
        stretch   = $urandom_range(20, 40);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int sent_random;
    int mode;
    int mode_left;
    bit fill_done;
    sent_random = 0;
    mode        = 0;
    mode_left   = 0;
    fill_done   = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // An empty print and refusals on an empty stack, then the value extremes and single-entry cases.
    send_request(REQ_PRINT, 32'h1234_5678);
    send_request(REQ_POP,   32'hFFFF_FFFF);
    send_request(REQ_SWAP,  32'h0000_0000);
    send_request(REQ_PUSH,  32'h8000_0000);
    send_request(REQ_SWAP,  32'hFFFF_FFFF);
    send_request(REQ_PRINT, 32'h0000_0000);
    send_request(REQ_PUSH,  32'h7FFF_FFFF);
    send_request(REQ_SWAP,  32'h0000_0000);
    send_request(REQ_PRINT, 32'hFFFF_FFFF);
    send_request(REQ_PUSH,  32'h0000_0000);
    send_request(REQ_PUSH,  32'hFFFF_FFFF);
    send_request(REQ_PUSH,  32'h5555_5555);
    send_request(REQ_PUSH,  32'hAAAA_AAAA);
    send_request(REQ_SWAP,  32'h5555_5555);
    send_request(REQ_PRINT, 32'hAAAA_AAAA);
    repeat (6) send_request(REQ_POP, $urandom);
    send_request(REQ_POP,   32'h8000_0000);
    send_request(REQ_SWAP,  32'h7FFF_FFFF);
    send_request(REQ_PRINT, 32'h0000_0000);
    drain_results();

    while (sent_random < RANDOM_ITEMS) begin
      if (!fill_done && sent_random >= 50) begin
        // Fill the stack while the receiver holds off, then overflow it.
        drain_results();
        long_hold_req = 1'b1;
        while (sb.shadow.size() < STACK_DEPTH) begin
          send_request(REQ_PUSH, pick_value());
          sent_random++;
        end
        send_request(REQ_PUSH, pick_value());
        send_request(REQ_PUSH, pick_value());
        send_request(REQ_PRINT, pick_value());
        send_request(REQ_SWAP, pick_value());
        send_request(REQ_PRINT, pick_value());
        sent_random += 5;
        fill_done = 1'b1;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(15, 35);
        gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 6;
      end
      send_request(pick_request(mode), pick_value());
      sent_random++;
      mode_left--;
    end

    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d requests (push %0d, pop %0d, swap %0d, print %0d), %0d results checked.",
             sb.req_seen[REQ_PUSH] + sb.req_seen[REQ_POP] + sb.req_seen[REQ_SWAP] +
             sb.req_seen[REQ_PRINT], sb.req_seen[REQ_PUSH], sb.req_seen[REQ_POP],
             sb.req_seen[REQ_SWAP], sb.req_seen[REQ_PRINT], sb.results_checked);
    $display("Refused: pop on empty %0d, short swap %0d, push on full %0d; deepest stack %0d of %0d.",
             sb.refusals[ST_POP_EMPTY], sb.refusals[ST_SWAP_SHORT], sb.refusals[ST_PUSH_FULL],
             sb.peak_depth, STACK_DEPTH);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("Mismatches: %0d", sb.mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/lss_pkg.sv
hw/rtl/lss_ctrl.sv
hw/rtl/lss_dpath.sv
hw/rtl/lifo_stack_push_pop_swap_core.sv
verif/tb_lifo_stack_push_pop_swap_core.sv
